/* src/cpt_pkg.sv */
// Shared widths, types and region codes for the closest-point-on-triangle core.
`default_nettype none
package cpt_pkg;

	localparam int COORD_W     = 31;
	localparam int DIFF_W      = COORD_W + 1;
	localparam int PROD_W      = 2 * DIFF_W;
	localparam int DOT_W       = PROD_W + 2;
	localparam int LO_W        = DOT_W / 2;
	localparam int HI_W        = DOT_W - LO_W;
	localparam int PD_W        = 2 * DOT_W;
	localparam int DET_W       = PD_W + 1;
	localparam int ND_W        = DOT_W + 1;
	localparam int DEN_W       = DET_W + 2;
	localparam int REM_W       = DEN_W + 1;
	localparam int WEIGHT_BITS = 32;
	localparam int WT_W        = WEIGHT_BITS + 1;
	localparam int MUL_W       = WT_W + 1 + DIFF_W;
	localparam int ACC_W       = MUL_W + 1;
	localparam int SUM_W       = ACC_W - WEIGHT_BITS + 1;

	localparam logic [2:0] REG_FACE = 3'd0;
	localparam logic [2:0] REG_AB   = 3'd1;
	localparam logic [2:0] REG_AC   = 3'd2;
	localparam logic [2:0] REG_BC   = 3'd3;
	localparam logic [2:0] REG_A    = 3'd4;
	localparam logic [2:0] REG_B    = 3'd5;
	localparam logic [2:0] REG_C    = 3'd6;

	// vert: a, b, c; edg: ab, ac, bc
	typedef struct packed {
		logic [2:0][2:0][COORD_W-1:0] vert;
		logic [2:0][2:0][DIFF_W-1:0]  edg;
	} geo_t;

	typedef struct packed {
		logic                   valid;
		geo_t                   geo;
		logic [5:0][DOT_W-1:0]  d;
	} dot_t;

	typedef struct packed {
		logic [2:0]              region;
		logic [2:0][COORD_W-1:0] base;
		logic [2:0][DIFF_W-1:0]  e1;
		logic [2:0][DIFF_W-1:0]  e2;
	} side_t;

	typedef struct packed {
		logic             valid;
		side_t            side;
		logic [DEN_W-1:0] num1;
		logic [DEN_W-1:0] num2;
		logic [DEN_W-1:0] den;
	} wreq_t;

	typedef struct packed {
		logic            valid;
		side_t           side;
		logic [WT_W-1:0] w1;
		logic [WT_W-1:0] w2;
	} wres_t;

endpackage
`default_nettype wire

/* src/cpt_dots.sv */
// Edge and offset differences and the six dot products (three stages).
`default_nettype none
module cpt_dots import cpt_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    in_valid,
	input  wire logic [2:0][COORD_W-1:0] p,
	input  wire logic [2:0][COORD_W-1:0] a,
	input  wire logic [2:0][COORD_W-1:0] b,
	input  wire logic [2:0][COORD_W-1:0] c,
	output dot_t                         dots
);

	function automatic logic [DIFF_W-1:0] sx(input logic [COORD_W-1:0] x);
		return {x[COORD_W-1], x};
	endfunction

	logic                              v_s1, v_s2, v_s3;
	geo_t                              geo_n, geo_s1, geo_s2, geo_s3;
	logic [2:0][2:0][DIFF_W-1:0]       off_n, off_s1;
	logic signed [PROD_W-1:0]          prod_n [6][3];
	logic signed [PROD_W-1:0]          prod_s2 [6][3];
	logic [5:0][DOT_W-1:0]             d_n, d_s3;

	// form edge and offset vectors
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			geo_n.vert[0][i] = a[i];
			geo_n.vert[1][i] = b[i];
			geo_n.vert[2][i] = c[i];
			geo_n.edg[0][i]  = sx(b[i]) - sx(a[i]);
			geo_n.edg[1][i]  = sx(c[i]) - sx(a[i]);
			geo_n.edg[2][i]  = sx(c[i]) - sx(b[i]);
			off_n[0][i]      = sx(p[i]) - sx(a[i]);
			off_n[1][i]      = sx(p[i]) - sx(b[i]);
			off_n[2][i]      = sx(p[i]) - sx(c[i]);
		end
	end

	// per-axis products: d1 ab.ap, d2 ac.ap, d3 ab.bp, d4 ac.bp, d5 ab.cp, d6 ac.cp
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			for (int i = 0; i < 3; i++) begin
				prod_n[k][i] = $signed(geo_s1.edg[k % 2][i]) * $signed(off_s1[k / 2][i]);
			end
		end
	end

	// sum axes
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			d_n[k] = DOT_W'(prod_s2[k][0]) + DOT_W'(prod_s2[k][1]) + DOT_W'(prod_s2[k][2]);
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s1  <= geo_n;
			off_s1  <= off_n;
			geo_s2  <= geo_s1;
			prod_s2 <= prod_n;
			geo_s3  <= geo_s2;
			d_s3    <= d_n;
		end
	end

	assign dots.valid = v_s3;
	assign dots.geo   = geo_s3;
	assign dots.d     = d_s3;

endmodule
`default_nettype wire

/* src/cpt_region.sv */
// Region determinants, Voronoi classification and weight request setup (four stages).
`default_nettype none
module cpt_region import cpt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  dot_t      dots,
	output wreq_t     req
);

	localparam int PX [6] = '{0, 2, 4, 0, 2, 4};
	localparam int PY [6] = '{3, 1, 1, 5, 5, 3};

	logic                          v_s4, v_s5, v_s6, v_s7;
	geo_t                          geo_s4, geo_s5, geo_s6;
	logic [5:0][DOT_W-1:0]         d_s4, d_s5, d_s6;
	logic signed [2*HI_W-1:0]      hh_n [6];
	logic signed [2*HI_W-1:0]      hh_s4 [6];
	logic signed [HI_W+LO_W:0]     hl_n [6];
	logic signed [HI_W+LO_W:0]     hl_s4 [6];
	logic signed [HI_W+LO_W:0]     lh_n [6];
	logic signed [HI_W+LO_W:0]     lh_s4 [6];
	logic [2*LO_W-1:0]             ll_n [6];
	logic [2*LO_W-1:0]             ll_s4 [6];
	logic [PD_W-1:0]               pd_n [6];
	logic [PD_W-1:0]               pd_s5 [6];
	logic signed [DET_W-1:0]       va_n, vb_n, vc_n, va_s6, vb_s6, vc_s6;
	logic signed [ND_W-1:0]        nab_n, nac_n, n3_n, m3_n;
	logic signed [ND_W-1:0]        nab_s6, nac_s6, n3_s6, m3_s6;
	wreq_t                         req_n, req_s7;

	// split determinant products into partial products
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			hh_n[k] = $signed(dots.d[PX[k]][DOT_W-1:LO_W]) * $signed(dots.d[PY[k]][DOT_W-1:LO_W]);
			hl_n[k] = $signed(dots.d[PX[k]][DOT_W-1:LO_W])
			        * $signed({1'b0, dots.d[PY[k]][LO_W-1:0]});
			lh_n[k] = $signed({1'b0, dots.d[PX[k]][LO_W-1:0]})
			        * $signed(dots.d[PY[k]][DOT_W-1:LO_W]);
			ll_n[k] = dots.d[PX[k]][LO_W-1:0] * dots.d[PY[k]][LO_W-1:0];
		end
	end

	// combine partial products
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			pd_n[k] = (PD_W'(hh_s4[k]) << (2 * LO_W))
			        + ((PD_W'(hl_s4[k]) + PD_W'(lh_s4[k])) << LO_W)
			        + PD_W'(ll_s4[k]);
		end
	end

	// determinants and edge differences
	always_comb begin
		vc_n  = DET_W'($signed(pd_s5[0])) - DET_W'($signed(pd_s5[1]));
		vb_n  = DET_W'($signed(pd_s5[2])) - DET_W'($signed(pd_s5[3]));
		va_n  = DET_W'($signed(pd_s5[4])) - DET_W'($signed(pd_s5[5]));
		nab_n = ND_W'($signed(d_s5[0])) - ND_W'($signed(d_s5[2]));
		nac_n = ND_W'($signed(d_s5[1])) - ND_W'($signed(d_s5[5]));
		n3_n  = ND_W'($signed(d_s5[3])) - ND_W'($signed(d_s5[2]));
		m3_n  = ND_W'($signed(d_s5[4])) - ND_W'($signed(d_s5[5]));
	end

	// classify and pick numerators, divisor, base and edges
	always_comb begin
		logic signed [DOT_W-1:0] d1, d2, d3, d6;
		d1 = $signed(d_s6[0]);
		d2 = $signed(d_s6[1]);
		d3 = $signed(d_s6[2]);
		d6 = $signed(d_s6[5]);
		req_n.valid       = v_s6;
		req_n.side.base   = geo_s6.vert[0];
		req_n.side.e1     = geo_s6.edg[0];
		req_n.side.e2     = geo_s6.edg[1];
		req_n.num1        = '0;
		req_n.num2        = '0;
		req_n.den         = '0;
		priority if (d1 <= 0 && d2 <= 0) begin
			req_n.side.region = REG_A;
		end else if (d3 >= 0 && n3_s6 <= 0) begin
			req_n.side.region = REG_B;
			req_n.side.base   = geo_s6.vert[1];
		end else if (d6 >= 0 && m3_s6 <= 0) begin
			req_n.side.region = REG_C;
			req_n.side.base   = geo_s6.vert[2];
		end else if (vc_s6 <= 0 && d1 >= 0 && d3 <= 0) begin
			req_n.side.region = REG_AB;
			req_n.num1        = DEN_W'(d1);
			req_n.den         = DEN_W'(nab_s6);
		end else if (vb_s6 <= 0 && d2 >= 0 && d6 <= 0) begin
			req_n.side.region = REG_AC;
			req_n.side.e1     = geo_s6.edg[1];
			req_n.num1        = DEN_W'(d2);
			req_n.den         = DEN_W'(nac_s6);
		end else if (va_s6 <= 0 && n3_s6 >= 0 && m3_s6 >= 0) begin
			req_n.side.region = REG_BC;
			req_n.side.base   = geo_s6.vert[1];
			req_n.side.e1     = geo_s6.edg[2];
			req_n.num1        = DEN_W'(n3_s6);
			req_n.den         = DEN_W'(n3_s6) + DEN_W'(m3_s6);
		end else begin
			req_n.side.region = REG_FACE;
			req_n.num1        = DEN_W'(vb_s6);
			req_n.num2        = DEN_W'(vc_s6);
			req_n.den         = DEN_W'(va_s6) + DEN_W'(vb_s6) + DEN_W'(vc_s6);
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s4 <= dots.valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s4 <= dots.geo;
			d_s4   <= dots.d;
			hh_s4  <= hh_n;
			hl_s4  <= hl_n;
			lh_s4  <= lh_n;
			ll_s4  <= ll_n;
			geo_s5 <= geo_s4;
			d_s5   <= d_s4;
			pd_s5  <= pd_n;
			geo_s6 <= geo_s5;
			d_s6   <= d_s5;
			va_s6  <= va_n;
			vb_s6  <= vb_n;
			vc_s6  <= vc_n;
			nab_s6 <= nab_n;
			nac_s6 <= nac_n;
			n3_s6  <= n3_n;
			m3_s6  <= m3_n;
			req_s7 <= req_n;
		end
	end

	always_comb begin
		req       = req_s7;
		req.valid = v_s7;
	end

endmodule
`default_nettype wire

/* src/cpt_weight.sv */
// Two-lane pipelined restoring divider for the region weights, one quotient bit per stage.
`default_nettype none
module cpt_weight import cpt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wreq_t     req,
	output wres_t     res
);

	localparam int NS = WEIGHT_BITS + 1;

	logic                       v_s   [NS];
	side_t                      sd_s  [NS];
	logic [REM_W-1:0]           den_s [NS][2];
	logic [REM_W-1:0]           rem_s [NS][2];
	logic [WEIGHT_BITS-1:0]     q_s   [NS][2];
	logic                       zero_s [NS][2];
	logic                       one_s  [NS][2];
	logic [REM_W-1:0]           rem0_n [2];
	logic                       zero0_n [2];
	logic                       one0_n [2];

	// clamp checks ahead of the division
	always_comb begin
		logic signed [DEN_W-1:0] num, den;
		for (int l = 0; l < 2; l++) begin
			num        = $signed((l == 0) ? req.num1 : req.num2);
			den        = $signed(req.den);
			zero0_n[l] = (den <= 0) || (num <= 0);
			one0_n[l]  = (num >= den);
			rem0_n[l]  = REM_W'(req.num1);
			if (l == 1) rem0_n[l] = REM_W'(req.num2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s[0] <= req.side;
			for (int l = 0; l < 2; l++) begin
				den_s[0][l]  <= REM_W'(req.den);
				rem_s[0][l]  <= rem0_n[l];
				q_s[0][l]    <= '0;
				zero_s[0][l] <= zero0_n[l];
				one_s[0][l]  <= one0_n[l];
			end
		end
	end

	// one shift-compare-subtract per stage
	for (genvar j = 0; j < WEIGHT_BITS; j++) begin : g_stage
		logic [REM_W-1:0] r2 [2];
		logic             ge [2];

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				r2[l] = {rem_s[j][l][REM_W-2:0], 1'b0};
				ge[l] = (r2[l] >= den_s[j][l]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sd_s[j+1] <= sd_s[j];
				for (int l = 0; l < 2; l++) begin
					den_s[j+1][l]  <= den_s[j][l];
					rem_s[j+1][l]  <= ge[l] ? (r2[l] - den_s[j][l]) : r2[l];
					q_s[j+1][l]    <= {q_s[j][l][WEIGHT_BITS-2:0], ge[l]};
					zero_s[j+1][l] <= zero_s[j][l];
					one_s[j+1][l]  <= one_s[j][l];
				end
			end
		end
	end

	// apply clamps to the finished quotients
	always_comb begin
		logic [WT_W-1:0] w [2];
		for (int l = 0; l < 2; l++) begin
			priority if (zero_s[NS-1][l]) w[l] = '0;
			else if (one_s[NS-1][l]) w[l] = {1'b1, {WEIGHT_BITS{1'b0}}};
			else w[l] = {1'b0, q_s[NS-1][l]};
		end
		res.valid = v_s[NS-1];
		res.side  = sd_s[NS-1];
		res.w1    = w[0];
		res.w2    = w[1];
	end

endmodule
`default_nettype wire

/* src/cpt_place.sv */
// Weighted edge sum, rounding, base offset and saturation of the closest point (three stages).
`default_nettype none
module cpt_place import cpt_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wres_t                         res,
	output logic                          out_valid,
	output logic [2:0][COORD_W-1:0]       near,
	output logic [2:0]                    region
);

	localparam logic signed [SUM_W-1:0] SAT_HI =
		{{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_LO =
		{{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] HALF =
		{{(ACC_W-WEIGHT_BITS){1'b0}}, 1'b1, {(WEIGHT_BITS-1){1'b0}}};

	logic                        v_p1, v_p2, v_p3;
	logic [2:0]                  reg_p1, reg_p2, reg_p3;
	logic [2:0][COORD_W-1:0]     base_p1, base_p2;
	logic signed [MUL_W-1:0]     m1_n [3];
	logic signed [MUL_W-1:0]     m2_n [3];
	logic signed [MUL_W-1:0]     m1_p1 [3];
	logic signed [MUL_W-1:0]     m2_p1 [3];
	logic signed [ACC_W-1:0]     acc_n [3];
	logic signed [ACC_W-1:0]     acc_p2 [3];
	logic [2:0][COORD_W-1:0]     near_n, near_p3;

	// weight times edge per axis
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m1_n[i] = $signed({1'b0, res.w1}) * $signed(res.side.e1[i]);
			m2_n[i] = $signed({1'b0, res.w2}) * $signed(res.side.e2[i]);
		end
	end

	// sum and add rounding half
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_n[i] = ACC_W'(m1_p1[i]) + ACC_W'(m2_p1[i]) + HALF;
		end
	end

	// drop fraction, add base, saturate
	always_comb begin
		logic signed [SUM_W-1:0] s;
		for (int i = 0; i < 3; i++) begin
			s = SUM_W'($signed(acc_p2[i][ACC_W-1:WEIGHT_BITS])) + SUM_W'($signed(base_p2[i]));
			priority if (s > SAT_HI) near_n[i] = SAT_HI[COORD_W-1:0];
			else if (s < SAT_LO) near_n[i] = SAT_LO[COORD_W-1:0];
			else near_n[i] = s[COORD_W-1:0];
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_p3 <= 1'b0;
		end else if (en) begin
			v_p1 <= res.valid;
			v_p2 <= v_p1;
			v_p3 <= v_p2;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			reg_p1  <= res.side.region;
			base_p1 <= res.side.base;
			m1_p1   <= m1_n;
			m2_p1   <= m2_n;
			reg_p2  <= reg_p1;
			base_p2 <= base_p1;
			acc_p2  <= acc_n;
			reg_p3  <= reg_p2;
			near_p3 <= near_n;
		end
	end

	assign out_valid = v_p3;
	assign near      = near_p3;
	assign region    = reg_p3;

endmodule
`default_nettype wire

/* src/closest_point_on_triangle_core.sv */
// Top level of the closest-point-on-triangle core.
//
// Usage: present a query point and three vertices (signed Q14.16) with
// in_valid; a request is taken at a clock edge where in_valid is high and
// in_stall is low. Each request yields one result: the closest point
// near_x/y/z on the triangle and its region code, under out_valid, taken
// when out_stall is low.
// Throughput: one request per cycle while no result waits under out_stall.
// Pipeline: three stages of differences and dot products, three of region
// determinants, one of classification, one of clamp checks, 32 of the
// two-lane divider (one quotient bit per stage) and three of weighting,
// rounding and saturation.
// Stall: the whole pipeline holds while a result waits under out_stall;
// in_stall follows out_stall only while a result is waiting, so bubbles
// keep moving. Nothing is dropped or repeated.
// Reset: arst_n clears all valid bits; the pipeline comes up empty and
// takes a request in the first cycle after reset.
`default_nettype none
module closest_point_on_triangle_core import cpt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [COORD_W-1:0] query_x,
	input  wire logic [COORD_W-1:0] query_y,
	input  wire logic [COORD_W-1:0] query_z,
	input  wire logic [COORD_W-1:0] vert_a_x,
	input  wire logic [COORD_W-1:0] vert_a_y,
	input  wire logic [COORD_W-1:0] vert_a_z,
	input  wire logic [COORD_W-1:0] vert_b_x,
	input  wire logic [COORD_W-1:0] vert_b_y,
	input  wire logic [COORD_W-1:0] vert_b_z,
	input  wire logic [COORD_W-1:0] vert_c_x,
	input  wire logic [COORD_W-1:0] vert_c_y,
	input  wire logic [COORD_W-1:0] vert_c_z,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [COORD_W-1:0]      near_x,
	output logic [COORD_W-1:0]      near_y,
	output logic [COORD_W-1:0]      near_z,
	output logic [2:0]              region
);

	logic                    en;
	dot_t                    dots;
	wreq_t                   req;
	wres_t                   res;
	logic [2:0][COORD_W-1:0] near;

	// advance the pipeline unless a finished result is held
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	cpt_dots u_dots (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.p        ({query_z, query_y, query_x}),
		.a        ({vert_a_z, vert_a_y, vert_a_x}),
		.b        ({vert_b_z, vert_b_y, vert_b_x}),
		.c        ({vert_c_z, vert_c_y, vert_c_x}),
		.dots     (dots)
	);

	cpt_region u_region (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.dots   (dots),
		.req    (req)
	);

	cpt_weight u_weight (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.req    (req),
		.res    (res)
	);

	cpt_place u_place (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.res       (res),
		.out_valid (out_valid),
		.near      (near),
		.region    (region)
	);

	assign near_x = near[0];
	assign near_y = near[1];
	assign near_z = near[2];

endmodule
`default_nettype wire
